[rtl/address_range_binary_search_defines.svh]
// Assertion macros for the address range search block.
// Both macros disappear when SYNTHESIS is defined.
`ifndef ADDRESS_RANGE_BINARY_SEARCH_DEFINES_SVH
`define ADDRESS_RANGE_BINARY_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked assertion that is disabled while the active-low reset is asserted.
`define ARBS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Clocked assertion that is also checked during reset.
`define ARBS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ARBS_ASSERT(label, clk, rst_n, prop, msg)
`define ARBS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[rtl/arbs_pkg.sv]
package arbs_pkg;

  // Width of the entry-count register.
  localparam int unsigned CntW  = 9;
  // Width of an address, a range start and a range size.
  localparam int unsigned AddrW = 31;
  // Width of the entry index on the stream ports.
  localparam int unsigned IdxW  = 8;
  // Input tdata width, padded to whole bytes.
  localparam int unsigned InDataW = 104;

  // Kind of an input transaction, carried in tuser.
  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_e;

  // One table entry as stored in the memory.
  typedef struct packed {
    logic [AddrW-1:0] size;
    logic [AddrW-1:0] start;
  } entry_t;

  // Status of the search sequencer.
  typedef struct packed {
    logic idle;
    logic probing;
    logic finishing;
  } status_t;

endpackage

[rtl/arbs_mem.sv]
module arbs_mem import arbs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [TABLE_DEPTH];
  entry_t rdata_q;

  // Single write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/arbs_ctrl.sv]
module arbs_ctrl import arbs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [CntW-1:0]    entry_count_i,
  // Input stream.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // tdata: entry_index, entry_start, entry_size, lookup_address, zero padding.
  input  logic [InDataW-1:0] s_axis_tdata,
  // tuser: action.
  input  logic               s_axis_tuser,
  // Result stream.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // tdata: hit_index.
  output logic [IdxW-1:0]    m_axis_tdata,
  // tuser: hit.
  output logic               m_axis_tuser,
  // Table memory.
  output logic               mem_we_o,
  output logic [AW-1:0]      mem_waddr_o,
  output entry_t             mem_wdata_o,
  output logic               mem_re_o,
  output logic [AW-1:0]      mem_raddr_o,
  input  entry_t             mem_rdata_i,
  output status_t            status_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_PROBE  = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   lo_q, lo_d;
  logic [CntW-1:0]   hix_q, hix_d;
  logic [CntW-1:0]   mid_q, mid_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic              res_hit_q, res_hit_d;
  logic [IdxW-1:0]   res_idx_q, res_idx_d;
  logic              out_valid_q, out_valid_d;
  logic              out_hit_q, out_hit_d;
  logic [IdxW-1:0]   out_idx_q, out_idx_d;

  logic              accept;
  action_e           in_action;
  logic [IdxW-1:0]   in_index;
  logic [AddrW-1:0]  in_start;
  logic [AddrW-1:0]  in_size;
  logic [AddrW-1:0]  in_addr;
  logic [CntW-1:0]   cnt_eff;
  logic [CntW-1:0]   init_mid;
  logic [AddrW:0]    end_addr;
  logic              go_left;
  logic              go_right;
  logic [CntW-1:0]   mid_left;
  logic [CntW-1:0]   mid_right;
  logic [CntW-1:0]   mid_p1;
  logic              left_more;
  logic              right_more;
  logic [CntW-1:0]   raddr;

  // Unpack the input transaction.
  assign in_action = action_e'(s_axis_tuser);
  assign in_index  = s_axis_tdata[7:0];
  assign in_start  = s_axis_tdata[38:8];
  assign in_size   = s_axis_tdata[69:39];
  assign in_addr   = s_axis_tdata[100:70];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Entry writes go straight to the memory in the cycle they are accepted.
  assign mem_we_o          = accept && (in_action == ACT_WRITE)
                             && (32'(in_index) < TABLE_DEPTH);
  assign mem_waddr_o       = AW'(in_index);
  assign mem_wdata_o.start = in_start;
  assign mem_wdata_o.size  = in_size;

  // Clamp the count to the table depth; the first probe sits at its middle.
  assign cnt_eff  = (32'(entry_count_i) > TABLE_DEPTH) ? CntW'(TABLE_DEPTH)
                                                       : entry_count_i;
  assign init_mid = CntW'(((CntW+1)'(cnt_eff) - (CntW+1)'(1)) >> 1);

  // Compare the probed range against the address; the end is one bit wider.
  assign end_addr = {1'b0, mem_rdata_i.start} + {1'b0, mem_rdata_i.size};
  assign go_left  = addr_q < mem_rdata_i.start;
  assign go_right = !go_left && ({1'b0, addr_q} >= end_addr);

  // Both possible next midpoints are formed from registers in parallel.
  // The upper bound hix_q is exclusive, so the live interval is [lo_q, hix_q).
  assign mid_p1     = mid_q + CntW'(1);
  assign mid_left   = CntW'(((CntW+1)'(lo_q) + (CntW+1)'(mid_q) - (CntW+1)'(1)) >> 1);
  assign mid_right  = CntW'(((CntW+1)'(mid_q) + (CntW+1)'(hix_q)) >> 1);
  assign left_more  = lo_q < mid_q;
  assign right_more = mid_p1 < hix_q;

  // Read address and enable for the next probe.
  always_comb begin
    raddr    = init_mid;
    mem_re_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        raddr    = init_mid;
        mem_re_o = accept && (in_action == ACT_LOOKUP) && (cnt_eff != '0);
      end
      ST_PROBE: begin
        raddr    = go_left ? mid_left : mid_right;
        mem_re_o = (go_left && left_more) || (go_right && right_more);
      end
      default: begin
        raddr    = init_mid;
        mem_re_o = 1'b0;
      end
    endcase
  end

  assign mem_raddr_o = AW'(raddr);

  // Search sequencer and output register.
  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hix_d       = hix_q;
    mid_d       = mid_q;
    addr_d      = addr_q;
    res_hit_d   = res_hit_q;
    res_idx_d   = res_idx_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_hit_d   = out_hit_q;
    out_idx_d   = out_idx_q;

    case (state_q)
      ST_IDLE: begin
        if (accept && (in_action == ACT_LOOKUP)) begin
          lo_d      = '0;
          hix_d     = cnt_eff;
          mid_d     = init_mid;
          addr_d    = in_addr;
          res_hit_d = 1'b0;
          res_idx_d = '0;
          state_d   = (cnt_eff == '0) ? ST_FINISH : ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (go_left) begin
          hix_d = mid_q;
          mid_d = mid_left;
          if (!left_more) begin
            state_d = ST_FINISH;
          end
        end else if (go_right) begin
          lo_d  = mid_p1;
          mid_d = mid_right;
          if (!right_more) begin
            state_d = ST_FINISH;
          end
        end else begin
          res_hit_d = 1'b1;
          res_idx_d = IdxW'(mid_q);
          state_d   = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hand the result over once the output register is free.
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_hit_d   = res_hit_q;
          out_idx_d   = res_idx_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q      <= lo_d;
    hix_q     <= hix_d;
    mid_q     <= mid_d;
    addr_q    <= addr_d;
    res_hit_q <= res_hit_d;
    res_idx_q <= res_idx_d;
    out_hit_q <= out_hit_d;
    out_idx_q <= out_idx_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = out_idx_q;

  assign status_o.idle      = (state_q == ST_IDLE);
  assign status_o.probing   = (state_q == ST_PROBE);
  assign status_o.finishing = (state_q == ST_FINISH);

endmodule

[rtl/address_range_binary_search.sv]
// Entry write: the next transaction is taken in the next cycle. Lookup: acceptance reads
// the first entry, each probe checks one and reads the next, and FINISH fills the output
// register and returns to IDLE. At most ceil(log2(count + 1)) = 9 probes for 256 entries;
// one probe per cycle is set by the single registered read port of the table memory. A
// result still held in the output register stalls the finishing step until it is taken.
// Reset clears the entry count and the control state; the table is undefined until written.
`include "address_range_binary_search_defines.svh"

module address_range_binary_search import arbs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Entry-count register.
  input  logic               cfg_we_i,
  input  logic [CntW-1:0]    cfg_wdata_i,
  // Input stream.
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // tdata: entry_index [7:0], entry_start [38:8], entry_size [69:39],
  // lookup_address [100:70], zero padding [103:101].
  input  logic [InDataW-1:0] s_axis_tdata_i,
  // tuser: action.
  input  logic               s_axis_tuser_i,
  // Result stream.
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // tdata: hit_index [7:0].
  output logic [IdxW-1:0]    m_axis_tdata_o,
  // tuser: hit.
  output logic               m_axis_tuser_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic [CntW-1:0] entry_count_q;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  entry_t          mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  entry_t          mem_rdata;
  status_t         ctrl_status;

  // Entry-count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_wdata_i;
    end
  end

  // Range table.
  arbs_mem #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Search sequencer.
  arbs_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_count_i (entry_count_q),
    .s_axis_tvalid (s_axis_tvalid_i),
    .s_axis_tready (s_axis_tready_o),
    .s_axis_tdata  (s_axis_tdata_i),
    .s_axis_tuser  (s_axis_tuser_i),
    .m_axis_tvalid (m_axis_tvalid_o),
    .m_axis_tready (m_axis_tready_i),
    .m_axis_tdata  (m_axis_tdata_o),
    .m_axis_tuser  (m_axis_tuser_o),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata),
    .status_o      (ctrl_status)
  );

  // A write transaction never starts a search.
  `ARBS_ASSERT(a_write_stays_idle, clk_i, rst_ni, (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == ACT_WRITE)) |=> ctrl_status.idle, "write transaction left the idle state")
  // A miss always reports index zero.
  `ARBS_ASSERT(a_miss_index_zero, clk_i, rst_ni, (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0), "miss with nonzero index")
  // A new result only comes out of the finishing step of a lookup.
  `ARBS_ASSERT(a_result_from_finish, clk_i, rst_ni, $rose(m_axis_tvalid_o) |-> $past(ctrl_status.finishing), "result without a finished lookup")

endmodule

[tb/address_range_binary_search_tb.sv]
`timescale 1ns / 100ps

module address_range_binary_search_tb;
  import arbs_pkg::*;

  localparam int unsigned TABLE_DEPTH = 256;
  // Cycles without any transaction before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 3000;
  // Cycles allowed for a lookup still in flight before the block counts as idle.
  localparam int unsigned SETTLE_CYCLES = 20;
  // Length of the long hold-off on the result side.
  localparam int unsigned LONG_HOLD = 200;

  // One input transaction, unpacked.
  typedef struct packed {
    action_e          act;
    logic [IdxW-1:0]  idx;
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] size;
    logic [AddrW-1:0] addr;
  } table_req_t;

  // One lookup answer.
  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] index;
  } lookup_res_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CntW-1:0]   cfg_wdata = '0;
  logic              s_valid = 1'b0;
  logic              s_axis_tready_o;
  logic [InDataW-1:0] s_axis_tdata;
  logic              s_axis_tuser;
  logic              m_axis_tvalid_o;
  logic              m_ready = 1'b0;
  logic [IdxW-1:0]   m_axis_tdata_o;
  logic              m_axis_tuser_o;

  // Current transaction on the input stream.
  table_req_t cur_item = '0;

  // Lookup answers still to come, oldest first.
  lookup_res_t expected_hits_q[$];
  // Transactions not yet handed to the input stream.
  table_req_t  pending_q[$];

  // Predictor state: table copy and entry count.
  logic [AddrW-1:0] tbl_start [TABLE_DEPTH];
  logic [AddrW-1:0] tbl_size  [TABLE_DEPTH];
  int unsigned      tbl_count = 0;

  // Stimulus-side view of the table, used to aim lookups at real ranges.
  logic [AddrW-1:0] gen_start [TABLE_DEPTH];
  logic [AddrW-1:0] gen_size  [TABLE_DEPTH];

  int  mismatch_cnt = 0;
  int  stall_cycles = 0;
  bit  in_taken = 1'b0;
  bit  quiet = 1'b0;
  bit  hold_request = 1'b0;

  // tdata: entry_index [7:0], entry_start [38:8], entry_size [69:39],
  // lookup_address [100:70], zero padding [103:101].
  assign s_axis_tdata = {3'b000, cur_item.addr, cur_item.size, cur_item.start, cur_item.idx};
  // tuser: action.
  assign s_axis_tuser = cur_item.act;

  address_range_binary_search #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // 20 ns clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Binary search over the predicted table, probing the midpoint each step.
  function automatic lookup_res_t search_table(logic [AddrW-1:0] addr);
    lookup_res_t res;
    int          lo;
    int          hi;
    int          mid;
    logic [31:0] s;
    logic [31:0] e;
    res = '0;
    lo = 0;
    hi = ((tbl_count > TABLE_DEPTH) ? TABLE_DEPTH : tbl_count) - 1;
    while (lo <= hi && !res.hit) begin
      mid = (lo + hi) / 2;
      s = {1'b0, tbl_start[mid]};
      e = s + {1'b0, tbl_size[mid]};
      if ({1'b0, addr} < s) begin
        hi = mid - 1;
      end else if ({1'b0, addr} >= e) begin
        lo = mid + 1;
      end else begin
        res.hit = 1'b1;
        res.index = mid[IdxW-1:0];
      end
    end
    return res;
  endfunction

  // Queue an entry write; the unused address field carries random bits.
  task automatic push_write(input int unsigned idx, input logic [AddrW-1:0] start,
                            input logic [AddrW-1:0] size);
    table_req_t req;
    req.act = ACT_WRITE;
    req.idx = idx[IdxW-1:0];
    req.start = start;
    req.size = size;
    req.addr = AddrW'($urandom);
    gen_start[idx] = start;
    gen_size[idx] = size;
    pending_q.push_back(req);
  endtask

  // Queue a lookup; the unused entry fields carry random bits.
  task automatic push_lookup(input logic [AddrW-1:0] addr);
    table_req_t req;
    req.act = ACT_LOOKUP;
    req.idx = IdxW'($urandom);
    req.start = AddrW'($urandom);
    req.size = AddrW'($urandom);
    req.addr = addr;
    pending_q.push_back(req);
  endtask

  // Address aimed inside, at the edges of, or away from a random live entry.
  function automatic logic [AddrW-1:0] pick_addr(int unsigned live);
    int unsigned j;
    logic [31:0] s;
    logic [31:0] sz;
    logic [31:0] a;
    j = $urandom_range(0, live - 1);
    s = {1'b0, gen_start[j]};
    sz = {1'b0, gen_size[j]};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: a = (sz == 0) ? s : s + ($urandom % sz);
      6: a = s + sz;
      7: a = s - 1;
      default: a = $urandom;
    endcase
    return a[AddrW-1:0];
  endfunction

  // Write the entry-count register; only called while the block is idle.
  task automatic set_entry_count(input int unsigned value);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value[CntW-1:0];
    @(negedge clk_i);
    cfg_we <= 1'b0;
    tbl_count = value;
  endtask

  // Wait until every transaction is sent and every answer is back.
  task automatic wait_idle();
    while (pending_q.size() != 0 || s_valid || expected_hits_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mixed traffic on a loaded table: mostly lookups, some size rewrites that
  // keep the order, and a few writes of random content that may break it.
  task automatic run_traffic(input int unsigned n, input int unsigned live);
    int unsigned r;
    int unsigned j;
    logic [31:0] room;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      j = $urandom_range(0, TABLE_DEPTH - 2);
      room = {1'b0, gen_start[j + 1]} - {1'b0, gen_start[j]};
      if (r < 4) begin
        push_write($urandom_range(0, TABLE_DEPTH - 1), AddrW'($urandom), AddrW'($urandom));
      end else if (r < 10 && gen_start[j + 1] > gen_start[j]) begin
        push_write(j, gen_start[j], AddrW'($urandom % (room + 1)));
      end else begin
        push_lookup(pick_addr(live));
      end
    end
  endtask

  // Input and output sampling, prediction, checking and the watchdog.
  always @(posedge clk_i) begin
    lookup_res_t want;
    bit          moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (s_valid && s_axis_tready_o) begin
        moved = 1'b1;
        in_taken = 1'b1;
        if (cur_item.act == ACT_LOOKUP) begin
          expected_hits_q.push_back(search_table(cur_item.addr));
        end else if (cur_item.idx < TABLE_DEPTH) begin
          tbl_start[cur_item.idx] = cur_item.start;
          tbl_size[cur_item.idx] = cur_item.size;
        end
      end
      if (m_axis_tvalid_o && m_ready) begin
        moved = 1'b1;
        if (expected_hits_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected result, expected none, actual hit %0b index %0d",
                   $time, m_axis_tuser_o, m_axis_tdata_o);
        end else begin
          want = expected_hits_q.pop_front();
          if (m_axis_tuser_o !== want.hit) begin
            mismatch_cnt++;
            $display("%0t: hit mismatch, expected %0b, actual %0b",
                     $time, want.hit, m_axis_tuser_o);
          end
          if (m_axis_tdata_o !== want.index) begin
            mismatch_cnt++;
            $display("%0t: hit_index mismatch, expected %0d, actual %0d",
                     $time, want.index, m_axis_tdata_o);
          end
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Input driver with random idle bursts.
  int unsigned src_gap = 0;
  int unsigned src_mode_left = 0;
  bit          src_bursty = 1'b0;

  always @(negedge clk_i) begin
    bit next_valid;
    if (rst_ni) begin
      next_valid = s_valid;
      if (in_taken) begin
        in_taken = 1'b0;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_q.size() > 0) begin
          if (!quiet && src_bursty && $urandom_range(0, 4) == 0) begin
            src_gap = $urandom_range(1, 15) - 1;
          end else begin
            cur_item = pending_q.pop_front();
            next_valid = 1'b1;
          end
        end
      end
      // Alternate between bursty and steady stretches.
      if (src_mode_left == 0) begin
        src_mode_left = $urandom_range(20, 80);
        src_bursty = ($urandom_range(0, 2) != 0);
      end else begin
        src_mode_left--;
      end
      s_valid <= next_valid;
    end
  end

  // Result receiver: random stall bursts plus one long hold-off on request.
  int unsigned sink_gap = 0;
  int unsigned hold_left = 0;
  int unsigned sink_mode_left = 0;
  bit          sink_bursty = 1'b0;

  always @(negedge clk_i) begin
    bit rdy;
    if (rst_ni) begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        rdy = 1'b0;
      end else if (!quiet && sink_bursty && $urandom_range(0, 5) == 0) begin
        sink_gap = $urandom_range(1, 15) - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      if (sink_mode_left == 0) begin
        sink_mode_left = $urandom_range(20, 80);
        sink_bursty = ($urandom_range(0, 2) != 0);
      end else begin
        sink_mode_left--;
      end
      m_ready <= rdy;
    end
  end

  // Stimulus sequence.
  initial begin
    logic [31:0] cursor;
    logic [31:0] st;
    logic [31:0] sz;
    int unsigned cnt;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty table: every lookup misses.
    set_entry_count(0);
    push_lookup(31'h0000_0000);
    push_lookup(31'h7FFF_FFFF);

    // Small table with an empty range and a range whose end passes 2^31.
    push_write(0, 31'h0000_0000, 31'h0000_0010);
    push_write(1, 31'h0000_0100, 31'h0000_0000);
    push_write(2, 31'h7FFF_FFF0, 31'h7FFF_FFFF);
    push_write(255, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    wait_idle();
    set_entry_count(3);
    push_lookup(31'h0000_0000);
    push_lookup(31'h0000_000F);
    push_lookup(31'h0000_0010);
    push_lookup(31'h0000_0100);
    push_lookup(31'h7FFF_FFFF);
    push_lookup(31'h7FFF_FFF0);
    push_lookup(31'h7FFF_FFEF);

    // Out-of-order entries: the search keeps its probe sequence and may miss.
    push_write(1, 31'h7FFF_FFFF, 31'h0000_0001);
    push_lookup(31'h7FFF_FFFF);
    push_lookup(31'h0000_0008);
    push_write(1, 31'h0000_0000, 31'h0000_0005);
    push_lookup(31'h0000_0008);
    wait_idle();

    // Single-entry table.
    set_entry_count(1);
    push_lookup(31'h0000_0005);
    push_lookup(31'h7FFF_FFFF);

    // Load a full ascending table with random gaps and sizes.
    cursor = $urandom_range(0, 1000);
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      st = cursor + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1 << 20));
      sz = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 1 << 21);
      if (j == TABLE_DEPTH - 1)
        sz = 32'h7FFF_FFFF;
      push_write(j, st[AddrW-1:0], sz[AddrW-1:0]);
      cursor = st + sz;
    end
    wait_idle();

    // Full depth, with the receiver holding off long enough to back up the input.
    set_entry_count(TABLE_DEPTH);
    hold_request = 1'b1;
    run_traffic(60, TABLE_DEPTH);
    wait_idle();

    // Count above the depth saturates to the depth.
    set_entry_count((1 << CntW) - 1);
    run_traffic(40, TABLE_DEPTH);
    wait_idle();

    // Assorted counts; the final stretch runs without idling.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: cnt = 2;
        1: cnt = 128;
        5: cnt = 255;
        default: cnt = $urandom_range(1, 255);
      endcase
      quiet = (p == 5);
      set_entry_count(cnt);
      run_traffic(25, cnt);
      wait_idle();
    end

    if (mismatch_cnt == 0 && expected_hits_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/arbs_pkg.sv
rtl/arbs_mem.sv
rtl/arbs_ctrl.sv
rtl/address_range_binary_search.sv
tb/address_range_binary_search_tb.sv
